// ----- rtl/tpq_pkg.sv -----
// Shared definitions for the two-class priority queue: operation and status
// codes, default depth and the command and status structs between controller
// and datapath. No dependencies.
package tpq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned TAG_W         = 16;

  localparam logic [1:0] OP_PUT_NORMAL   = 2'd0;
  localparam logic [1:0] OP_PUT_PRIORITY = 2'd1;
  localparam logic [1:0] OP_GET          = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic       load;
    logic       put_normal;
    logic       put_prio;
    logic       get;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic prio_any;
  } stat_t;

endpackage

// ----- rtl/two_class_priority_queue_unit.sv -----
// Two-class priority queue of DEPTH entries, each a 32-bit payload with a
// 16-bit arrival tag. A priority put lands behind earlier priority entries and
// ahead of all normal ones; a normal put appends; a get removes the head. A put
// on a full queue or a get on an empty one returns a refusal status and changes
// nothing. The block takes one item per clock cycle while its output is not
// stalled and gives its result in the next cycle from an output register: the
// entries sit in a shift register that moves every place in parallel.
// A result left stalled at the output holds back only the next input item.
// Depends on tpq_pkg, tpq_controller and tpq_datapath.
module two_class_priority_queue_unit #(
  parameter int unsigned DEPTH = tpq_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  operation_i,
  input  logic [tpq_pkg::DATA_W-1:0]  payload_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [tpq_pkg::TAG_W-1:0]   arrival_tag_o,
  output logic [tpq_pkg::DATA_W-1:0]  data_out_o,
  output logic                        was_priority_o
);
  import tpq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tpq_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tpq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .payload_i      (payload_i),
    .stat_o         (stat),
    .status_o       (status_o),
    .arrival_tag_o  (arrival_tag_o),
    .data_out_o     (data_out_o),
    .was_priority_o (was_priority_o)
  );

endmodule

// ----- rtl/tpq_datapath.sv -----
// Datapath of the two-class priority queue: the shift-register entry store,
// occupancy and priority counters, arrival counter and result register.
// Depends on tpq_pkg.
module tpq_datapath #(
  parameter int unsigned DEPTH = tpq_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tpq_pkg::cmd_t               cmd_i,
  input  logic [tpq_pkg::DATA_W-1:0]  payload_i,
  output tpq_pkg::stat_t              stat_o,
  output logic [1:0]                  status_o,
  output logic [tpq_pkg::TAG_W-1:0]   arrival_tag_o,
  output logic [tpq_pkg::DATA_W-1:0]  data_out_o,
  output logic                        was_priority_o
);
  import tpq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] data_q [DEPTH];
  logic [DATA_W-1:0] data_d [DEPTH];
  logic [TAG_W-1:0]  tag_q  [DEPTH];
  logic [TAG_W-1:0]  tag_d  [DEPTH];
  logic [DATA_W-1:0] data_prev [DEPTH];
  logic [DATA_W-1:0] data_next [DEPTH];
  logic [TAG_W-1:0]  tag_prev  [DEPTH];
  logic [TAG_W-1:0]  tag_next  [DEPTH];

  logic [CW-1:0]     occ_q, occ_d;
  logic [CW-1:0]     prio_q, prio_d;
  logic [TAG_W-1:0]  arr_q, arr_d;
  logic [CW-1:0]     slot;
  logic              put;

  logic [1:0]        res_status_q;
  logic [TAG_W-1:0]  res_tag_q;
  logic [DATA_W-1:0] res_data_q;
  logic              res_prio_q;

  assign put  = cmd_i.put_normal | cmd_i.put_prio;
  assign slot = cmd_i.put_prio ? prio_q : occ_q;

  assign stat_o.full     = (occ_q == CW'(DEPTH));
  assign stat_o.empty    = (occ_q == '0);
  assign stat_o.prio_any = (prio_q != '0);

  // Neighbor taps of the shift line; the ends feed zero.
  for (genvar g = 0; g < DEPTH; g++) begin : g_tap
    if (g == 0) begin : g_first
      assign data_prev[g] = '0;
      assign tag_prev[g]  = '0;
    end else begin : g_mid_prev
      assign data_prev[g] = data_q[g-1];
      assign tag_prev[g]  = tag_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign data_next[g] = '0;
      assign tag_next[g]  = '0;
    end else begin : g_mid_next
      assign data_next[g] = data_q[g+1];
      assign tag_next[g]  = tag_q[g+1];
    end
  end

  // A put writes its slot and pushes everything behind it back by one place.
  // Entries beyond the occupancy are don't-care, so they shift along freely.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      data_d[i] = data_q[i];
      tag_d[i]  = tag_q[i];
      if (put) begin
        if (CW'(i) == slot) begin
          data_d[i] = payload_i;
          tag_d[i]  = arr_q;
        end else if (CW'(i) > slot) begin
          data_d[i] = data_prev[i];
          tag_d[i]  = tag_prev[i];
        end
      end else if (cmd_i.get) begin
        data_d[i] = data_next[i];
        tag_d[i]  = tag_next[i];
      end
    end
  end

  always_comb begin
    occ_d  = occ_q;
    prio_d = prio_q;
    arr_d  = arr_q;
    if (put) begin
      occ_d = occ_q + CW'(1);
      arr_d = arr_q + TAG_W'(1);
    end
    if (cmd_i.put_prio) begin
      prio_d = prio_q + CW'(1);
    end
    if (cmd_i.get) begin
      occ_d = occ_q - CW'(1);
      if (stat_o.prio_any) begin
        prio_d = prio_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      data_q[i] <= data_d[i];
      tag_q[i]  <= tag_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      prio_q <= '0;
      arr_q  <= '0;
    end else begin
      occ_q  <= occ_d;
      prio_q <= prio_d;
      arr_q  <= arr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_status_q <= cmd_i.status;
      res_tag_q    <= put ? arr_q : (cmd_i.get ? tag_q[0] : '0);
      res_data_q   <= cmd_i.get ? data_q[0] : '0;
      res_prio_q   <= cmd_i.get & stat_o.prio_any;
    end
  end

  assign status_o       = res_status_q;
  assign arrival_tag_o  = res_tag_q;
  assign data_out_o     = res_data_q;
  assign was_priority_o = res_prio_q;

  a_prio_le_occ : assert property (@(posedge clk_i) disable iff (!rst_ni)
    prio_q <= occ_q) else $error("priority count exceeds occupancy");

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(DEPTH)) else $error("occupancy exceeds depth");

  a_put_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    put |=> (occ_q == $past(occ_q) + CW'(1)) && (arr_q == $past(arr_q) + TAG_W'(1)))
    else $error("put did not advance occupancy and arrival number");

endmodule

// ----- rtl/tpq_controller.sv -----
// Controller of the two-class priority queue: handshake state machine and
// operation decode into datapath commands. Depends on tpq_pkg.
module tpq_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     operation_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  tpq_pkg::stat_t stat_i,
  output tpq_pkg::cmd_t  cmd_o
);
  import tpq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // The result register is free when empty or being drained this cycle.
  assign in_stall_o  = (state_q == S_RESULT) && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_RESULT);

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = accept;
    cmd_o.status = ST_DONE;
    if (accept) begin
      case (operation_i)
        OP_PUT_NORMAL: begin
          if (stat_i.full) cmd_o.status = ST_FULL;
          else             cmd_o.put_normal = 1'b1;
        end
        OP_PUT_PRIORITY: begin
          if (stat_i.full) cmd_o.status = ST_FULL;
          else             cmd_o.put_prio = 1'b1;
        end
        OP_GET: begin
          if (stat_i.empty) cmd_o.status = ST_EMPTY;
          else              cmd_o.get = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_RESULT;
      end
      S_RESULT: begin
        if (accept)            state_d = S_RESULT;
        else if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_cmd_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.put_normal, cmd_o.put_prio, cmd_o.get}))
    else $error("more than one queue command at once");

  a_no_get_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.empty |-> !cmd_o.get) else $error("get issued on empty queue");

  a_no_put_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.full |-> !(cmd_o.put_normal || cmd_o.put_prio))
    else $error("put issued on full queue");

  a_cmd_needs_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.put_normal || cmd_o.put_prio || cmd_o.get) |-> accept)
    else $error("queue command without an accepted item");

endmodule
